[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/mfc_pkg.sv]
// Shared constants and codes for the multichannel filter correlation block.
package mfc_pkg;

  localparam int MFC_MAX_MAP_DIM    = 64;
  localparam int MFC_MAX_FILTER_DIM = 32;
  localparam int MFC_MAX_CHANNELS   = 32;

  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int SCORE_W = 48;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 3;

  // Commands.
  localparam logic [1:0] CMD_FEAT_WR = 2'd0;
  localparam logic [1:0] CMD_FILT_WR = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_MAP_ROWS  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MAP_COLS  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_FILT_ROWS = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_FILT_COLS = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_CHANNELS  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [6:0] RST_MAP_ROWS  = 7'd64;
  localparam logic [6:0] RST_MAP_COLS  = 7'd64;
  localparam logic [5:0] RST_FILT_ROWS = 6'd6;
  localparam logic [5:0] RST_FILT_COLS = 6'd6;
  localparam logic [5:0] RST_CHANNELS  = 6'd32;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

[hdl/mfc_ram.sv]
// Generic single-port RAM with registered read data.
module mfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/multichannel_filter_correlation.sv]
// Top level: feature and filter stores with a sequenced multiply-accumulate scorer.
//
//   channel  direction  handshake         payload
//   in       input      valid / stall     cmd, channel, row, col, value
//   out      output     valid / stall     score, status
//   cfg      input      valid / ready     index, data
//
// A write or unused command is answered from the output register in the cycle after
// it is taken. A compute command reads its channels * filter_rows * filter_cols terms
// through one read port on each store feeding a single multiplier and accumulator.
// A compute that fails its error checks skips the stores. Reset clears control and sets
// the configuration defaults, not the stores. A stalled result holds the next write, but
// a compute command is still taken and waits for the output register at its end.
module multichannel_filter_correlation
  import mfc_pkg::*;
#(
  parameter int MAX_MAP_DIM    = MFC_MAX_MAP_DIM,
  parameter int MAX_FILTER_DIM = MFC_MAX_FILTER_DIM,
  parameter int MAX_CHANNELS   = MFC_MAX_CHANNELS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                in_cmd_i,
  input  logic [4:0]                in_channel_i,
  input  logic [5:0]                in_row_i,
  input  logic [5:0]                in_col_i,
  input  logic signed [VAL_W-1:0]   in_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SCORE_W-1:0] out_score_o,
  output logic                      out_status_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CIDX_W-1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i
);

`include "assert_macros.svh"

  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MAP_W   = $clog2(MAX_MAP_DIM);
  localparam int FLT_W   = $clog2(MAX_FILTER_DIM);
  localparam int SUM_W   = ((MAP_W > 6) ? MAP_W : 6) + 1;
  localparam int FEAT_AW = CH_W + 2 * MAP_W;
  localparam int FILT_AW = CH_W + 2 * FLT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration.
  logic [6:0] map_rows_q, map_cols_q;
  logic [5:0] filt_rows_q, filt_cols_q, chan_cnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q  <= RST_MAP_ROWS;
      map_cols_q  <= RST_MAP_COLS;
      filt_rows_q <= RST_FILT_ROWS;
      filt_cols_q <= RST_FILT_COLS;
      chan_cnt_q  <= RST_CHANNELS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_ROWS:  map_rows_q  <= cfg_data_i;
        CFG_MAP_COLS:  map_cols_q  <= cfg_data_i;
        CFG_FILT_ROWS: filt_rows_q <= cfg_data_i[5:0];
        CFG_FILT_COLS: filt_cols_q <= cfg_data_i[5:0];
        CFG_CHANNELS:  chan_cnt_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  logic out_valid_q, out_status_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic out_free, in_accept, is_compute;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_compute = (in_cmd_i == CMD_COMPUTE);
  assign in_stall_o = (state_q != S_IDLE) || (!out_free && !is_compute);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Range checks for writes.
  logic feat_ok, filt_ok;
  assign feat_ok = (32'(in_channel_i) < MAX_CHANNELS) && (32'(in_row_i) < MAX_MAP_DIM) &&
                   (32'(in_col_i) < MAX_MAP_DIM);
  assign filt_ok = (32'(in_channel_i) < MAX_CHANNELS) && (32'(in_row_i) < MAX_FILTER_DIM) &&
                   (32'(in_col_i) < MAX_FILTER_DIM);

  // Checks for compute.
  logic dims_bad, window_bad;
  logic [7:0] row_end, col_end;
  logic [6:0] nch;
  assign dims_bad = (map_rows_q == '0) || (32'(map_rows_q) > MAX_MAP_DIM) ||
                    (map_cols_q == '0) || (32'(map_cols_q) > MAX_MAP_DIM) ||
                    (filt_rows_q == '0) || (32'(filt_rows_q) > MAX_FILTER_DIM) ||
                    (filt_cols_q == '0) || (32'(filt_cols_q) > MAX_FILTER_DIM);
  assign row_end    = 8'(in_row_i) + 8'(filt_rows_q);
  assign col_end    = 8'(in_col_i) + 8'(filt_cols_q);
  assign window_bad = (row_end > 8'(map_rows_q)) || (col_end > 8'(map_cols_q));
  assign nch = (32'(chan_cnt_q) > MAX_CHANNELS) ? 7'(MAX_CHANNELS) : 7'(chan_cnt_q);

  // Loop counters: channel outermost, then filter column, then filter row.
  logic [5:0] row_q, col_q;
  logic [6:0] ch_q, nch_q;
  logic [5:0] fr_q, fc_q;
  logic fr_last, fc_last, ch_last;
  assign fr_last = (fr_q == filt_rows_q - 6'd1);
  assign fc_last = (fc_q == filt_cols_q - 6'd1);
  assign ch_last = (ch_q == nch_q - 7'd1);

  // Store addresses.
  logic [SUM_W-1:0] rd_row, rd_col, wr_row, wr_col;
  logic [5:0] ch_ext;
  logic [FEAT_AW-1:0] feat_addr;
  logic [FILT_AW-1:0] filt_addr;
  logic feat_we, filt_we;
  logic [VAL_W-1:0] feat_rd, filt_rd;

  assign rd_row = SUM_W'(row_q) + SUM_W'(fr_q);
  assign rd_col = SUM_W'(col_q) + SUM_W'(fc_q);
  assign wr_row = SUM_W'(in_row_i);
  assign wr_col = SUM_W'(in_col_i);
  assign ch_ext = 6'(in_channel_i);

  always_comb begin
    if (state_q == S_IDLE) begin
      feat_addr = {ch_ext[CH_W-1:0], wr_row[MAP_W-1:0], wr_col[MAP_W-1:0]};
      filt_addr = {ch_ext[CH_W-1:0], in_row_i[FLT_W-1:0], in_col_i[FLT_W-1:0]};
    end else begin
      feat_addr = {ch_q[CH_W-1:0], rd_row[MAP_W-1:0], rd_col[MAP_W-1:0]};
      filt_addr = {ch_q[CH_W-1:0], fr_q[FLT_W-1:0], fc_q[FLT_W-1:0]};
    end
  end

  assign feat_we = in_accept && (in_cmd_i == CMD_FEAT_WR) && feat_ok;
  assign filt_we = in_accept && (in_cmd_i == CMD_FILT_WR) && filt_ok;

  mfc_ram #(
    .WIDTH(VAL_W),
    .DEPTH(1 << FEAT_AW)
  ) u_feat_ram (
    .clk_i  (clk_i),
    .we_i   (feat_we),
    .addr_i (feat_addr),
    .wdata_i(in_value_i),
    .rdata_o(feat_rd)
  );

  mfc_ram #(
    .WIDTH(VAL_W),
    .DEPTH(1 << FILT_AW)
  ) u_filt_ram (
    .clk_i  (clk_i),
    .we_i   (filt_we),
    .addr_i (filt_addr),
    .wdata_i(in_value_i),
    .rdata_o(filt_rd)
  );

  // Read, multiply and accumulate pipeline.
  logic rd_v_q, prod_v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SCORE_W-1:0] acc_q;
  logic signed [SCORE_W:0] acc_sum;
  logic signed [SCORE_W-1:0] acc_sat;
  logic stat_q;
  logic run_issue, all_last;

  assign run_issue = (state_q == S_RUN);
  assign all_last  = fr_last && fc_last && ch_last;

  assign acc_sum = (SCORE_W + 1)'(acc_q) + (SCORE_W + 1)'(prod_q);
  always_comb begin
    if (acc_sum[SCORE_W] != acc_sum[SCORE_W-1]) begin
      // Overflow past either rail: clamp toward the sign of the true sum.
      acc_sat = acc_sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(feat_rd) * $signed(filt_rd);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && is_compute) begin
          if (dims_bad || window_bad || nch == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (all_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !prod_v_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= run_issue;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      row_q <= in_row_i;
      col_q <= in_col_i;
      nch_q <= nch;
      ch_q  <= '0;
      fr_q  <= '0;
      fc_q  <= '0;
      acc_q <= '0;
      stat_q <= (dims_bad || window_bad) ? STATUS_ERR : STATUS_OK;
    end else begin
      if (run_issue) begin
        if (fr_last) begin
          fr_q <= '0;
          if (fc_last) begin
            fc_q <= '0;
            ch_q <= ch_q + 7'd1;
          end else begin
            fc_q <= fc_q + 6'd1;
          end
        end else begin
          fr_q <= fr_q + 6'd1;
        end
      end
      if (prod_v_q) begin
        acc_q <= acc_sat;
      end
    end
  end

  // Output register.
  logic ld_write, ld_done;
  assign ld_write = in_accept && !is_compute;
  assign ld_done  = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_write || ld_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_write) begin
      out_score_q <= '0;
      case (in_cmd_i)
        CMD_FEAT_WR: out_status_q <= feat_ok ? STATUS_OK : STATUS_ERR;
        CMD_FILT_WR: out_status_q <= filt_ok ? STATUS_OK : STATUS_ERR;
        default:     out_status_q <= STATUS_ERR;
      endcase
    end else if (ld_done) begin
      out_score_q  <= acc_q;
      out_status_q <= stat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_score_o  = out_score_q;
  assign out_status_o = out_status_q;

  `ASSERT_IMPLY(a_accept_idle, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_IDLE)
  `ASSERT_NEXT(a_compute_leaves_idle, clk_i, rst_ni, in_accept && is_compute, state_q != S_IDLE)
  `ASSERT_IMPLY(a_done_drained, clk_i, rst_ni, state_q == S_DONE, !rd_v_q && !prod_v_q)
  `ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, out_valid_o && out_status_o, out_score_o == '0)

endmodule

[tb/mfc_score_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the correlation block: mirrors its stores and checks every result beat.
module mfc_score_checker
  import mfc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [1:0]                in_cmd_i,
  input  logic [4:0]                in_channel_i,
  input  logic [5:0]                in_row_i,
  input  logic [5:0]                in_col_i,
  input  logic signed [VAL_W-1:0]   in_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [SCORE_W-1:0] out_score_i,
  input  logic                      out_status_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CIDX_W-1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output int                        pending_o,
  output int                        fail_count_o
);

  localparam int FEAT_WORDS = MFC_MAX_CHANNELS * MFC_MAX_MAP_DIM * MFC_MAX_MAP_DIM;
  localparam int FILT_WORDS = MFC_MAX_CHANNELS * MFC_MAX_FILTER_DIM * MFC_MAX_FILTER_DIM;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      status;
  } score_beat_t;

  logic signed [VAL_W-1:0] feature_mem [FEAT_WORDS];
  logic signed [VAL_W-1:0] weight_mem [FILT_WORDS];
  logic [6:0] map_rows;
  logic [6:0] map_cols;
  logic [5:0] filt_rows;
  logic [5:0] filt_cols;
  logic [5:0] channels;
  score_beat_t scores_due [$];
  score_beat_t head;
  score_beat_t fresh;

  // Sum order is channel, then filter column, then filter row; the clamp follows every add.
  function automatic score_beat_t correlate_window(input int unsigned row,
                                                   input int unsigned col);
    score_beat_t beat;
    longint sum;
    int unsigned nch, ch, fr, fc, fa, wa;
    beat.score = '0;
    beat.status = STATUS_ERR;
    sum = 0;
    if (map_rows == 0 || map_rows > MFC_MAX_MAP_DIM || map_cols == 0 ||
        map_cols > MFC_MAX_MAP_DIM || filt_rows == 0 || filt_rows > MFC_MAX_FILTER_DIM ||
        filt_cols == 0 || filt_cols > MFC_MAX_FILTER_DIM) begin
      return beat;
    end
    if (row + filt_rows > map_rows || col + filt_cols > map_cols) begin
      return beat;
    end
    nch = (channels > MFC_MAX_CHANNELS) ? MFC_MAX_CHANNELS : channels;
    for (ch = 0; ch < nch; ch++) begin
      for (fc = 0; fc < filt_cols; fc++) begin
        for (fr = 0; fr < filt_rows; fr++) begin
          fa = (ch * MFC_MAX_MAP_DIM + row + fr) * MFC_MAX_MAP_DIM + col + fc;
          wa = (ch * MFC_MAX_FILTER_DIM + fr) * MFC_MAX_FILTER_DIM + fc;
          sum += longint'(feature_mem[fa]) * longint'(weight_mem[wa]);
          if (sum > SUM_MAX) sum = SUM_MAX;
          if (sum < SUM_MIN) sum = SUM_MIN;
        end
      end
    end
    beat.score = sum[SCORE_W-1:0];
    beat.status = STATUS_OK;
    return beat;
  endfunction

  function automatic score_beat_t apply_command(input logic [1:0] cmd,
                                                input int unsigned ch,
                                                input int unsigned row,
                                                input int unsigned col,
                                                input logic signed [VAL_W-1:0] value);
    score_beat_t beat;
    beat.score = '0;
    beat.status = STATUS_ERR;
    case (cmd)
      CMD_FEAT_WR: begin
        if (ch < MFC_MAX_CHANNELS && row < MFC_MAX_MAP_DIM && col < MFC_MAX_MAP_DIM) begin
          feature_mem[(ch * MFC_MAX_MAP_DIM + row) * MFC_MAX_MAP_DIM + col] = value;
          beat.status = STATUS_OK;
        end
      end
      CMD_FILT_WR: begin
        if (ch < MFC_MAX_CHANNELS && row < MFC_MAX_FILTER_DIM &&
            col < MFC_MAX_FILTER_DIM) begin
          weight_mem[(ch * MFC_MAX_FILTER_DIM + row) * MFC_MAX_FILTER_DIM + col] = value;
          beat.status = STATUS_OK;
        end
      end
      CMD_COMPUTE: beat = correlate_window(row, col);
      default: ;
    endcase
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scores_due.delete();
      map_rows = RST_MAP_ROWS;
      map_cols = RST_MAP_COLS;
      filt_rows = RST_FILT_ROWS;
      filt_cols = RST_FILT_COLS;
      channels = RST_CHANNELS;
    end else begin
      // Compare before predicting so a stray beat cannot consume a fresh expectation.
      if (out_valid_i && !out_stall_i) begin
        if (scores_due.size() == 0) begin
          $error("result beat with nothing outstanding: score %0d, status %0d",
                 out_score_i, out_status_i);
          fail_count_o++;
        end else begin
          head = scores_due.pop_front();
          if (out_score_i !== head.score) begin
            $error("score mismatch: expected %0d, actual %0d", head.score, out_score_i);
            fail_count_o++;
          end
          if (out_status_i !== head.status) begin
            $error("status mismatch: expected %0d, actual %0d", head.status, out_status_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAP_ROWS:  map_rows = cfg_data_i;
          CFG_MAP_COLS:  map_cols = cfg_data_i;
          CFG_FILT_ROWS: filt_rows = cfg_data_i[5:0];
          CFG_FILT_COLS: filt_cols = cfg_data_i[5:0];
          CFG_CHANNELS:  channels = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        fresh = apply_command(in_cmd_i, in_channel_i, in_row_i, in_col_i, in_value_i);
        scores_due = {scores_due, fresh};
      end
    end
    pending_o = scores_due.size();
  end

endmodule

[tb/tb_multichannel_filter_correlation.sv]
`timescale 1ns / 100ps
// Regression top for the correlation block: clock, reset, stimulus, flow control and verdict.
module tb_multichannel_filter_correlation;
  import mfc_pkg::*;

  localparam logic [1:0]        CMD_UNUSED = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_SPARE  = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;
  localparam int FEAT_WORDS   = MFC_MAX_CHANNELS * MFC_MAX_MAP_DIM * MFC_MAX_MAP_DIM;
  localparam int FILT_WORDS   = MFC_MAX_CHANNELS * MFC_MAX_FILTER_DIM * MFC_MAX_FILTER_DIM;
  localparam int RANDOM_ITEMS = 520;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_FEAT_WR;
  logic [4:0] in_channel = '0;
  logic [5:0] in_row = '0;
  logic [5:0] in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SCORE_W-1:0] out_score;
  logic out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int pending;
  int fail_count;
  int cycles = 0;
  int sent_items = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  // Settings as last written, used to keep every compute on loaded cells and to pick ranges.
  int unsigned sh_map_rows = RST_MAP_ROWS;
  int unsigned sh_map_cols = RST_MAP_COLS;
  int unsigned sh_filt_rows = RST_FILT_ROWS;
  int unsigned sh_filt_cols = RST_FILT_COLS;
  int unsigned sh_channels = RST_CHANNELS;
  bit feat_loaded [FEAT_WORDS];
  bit filt_loaded [FILT_WORDS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multichannel_filter_correlation u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_cmd_i     (in_cmd),
    .in_channel_i (in_channel),
    .in_row_i     (in_row),
    .in_col_i     (in_col),
    .in_value_i   (in_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_score_o  (out_score),
    .out_status_o (out_status),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  mfc_score_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_cmd_i     (in_cmd),
    .in_channel_i (in_channel),
    .in_row_i     (in_row),
    .in_col_i     (in_col),
    .in_value_i   (in_value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_score_i  (out_score),
    .out_status_i (out_status),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      default: return r[VAL_W-1:0];
    endcase
  endfunction

  function automatic int unsigned feat_addr(input int unsigned ch, input int unsigned row,
                                            input int unsigned col);
    return (ch * MFC_MAX_MAP_DIM + row) * MFC_MAX_MAP_DIM + col;
  endfunction

  function automatic int unsigned filt_addr(input int unsigned ch, input int unsigned row,
                                            input int unsigned col);
    return (ch * MFC_MAX_FILTER_DIM + row) * MFC_MAX_FILTER_DIM + col;
  endfunction

  function automatic int unsigned clip_span(input int unsigned x, input int unsigned hi);
    if (x < 1) return 1;
    if (x > hi) return hi;
    return x;
  endfunction

  // True when a compute at this location passes the size and window checks.
  function automatic bit window_reads(input int unsigned row, input int unsigned col);
    if (sh_map_rows < 1 || sh_map_rows > MFC_MAX_MAP_DIM || sh_map_cols < 1 ||
        sh_map_cols > MFC_MAX_MAP_DIM || sh_filt_rows < 1 ||
        sh_filt_rows > MFC_MAX_FILTER_DIM || sh_filt_cols < 1 ||
        sh_filt_cols > MFC_MAX_FILTER_DIM) begin
      return 1'b0;
    end
    return (row + sh_filt_rows <= sh_map_rows) && (col + sh_filt_cols <= sh_map_cols);
  endfunction

  task automatic send_command(input logic [1:0] cmd, input int unsigned ch,
                              input int unsigned row, input int unsigned col,
                              input logic signed [VAL_W-1:0] value);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_channel <= ch[4:0];
    in_row <= row[5:0];
    in_col <= col[5:0];
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (cmd == CMD_FEAT_WR) feat_loaded[feat_addr(ch, row, col)] = 1'b1;
    if (cmd == CMD_FILT_WR && row < MFC_MAX_FILTER_DIM && col < MFC_MAX_FILTER_DIM) begin
      filt_loaded[filt_addr(ch, row, col)] = 1'b1;
    end
  endtask

  // Loads whatever the window still lacks, then asks for the score.
  task automatic issue_compute(input int unsigned row, input int unsigned col);
    int unsigned nch, ch, fr, fc;
    if (window_reads(row, col)) begin
      nch = (sh_channels > MFC_MAX_CHANNELS) ? MFC_MAX_CHANNELS : sh_channels;
      for (ch = 0; ch < nch; ch++) begin
        for (fr = 0; fr < sh_filt_rows; fr++) begin
          for (fc = 0; fc < sh_filt_cols; fc++) begin
            if (!feat_loaded[feat_addr(ch, row + fr, col + fc)]) begin
              send_command(CMD_FEAT_WR, ch, row + fr, col + fc, rand_value());
            end
            if (!filt_loaded[filt_addr(ch, fr, fc)]) begin
              send_command(CMD_FILT_WR, ch, fr, fc, rand_value());
            end
          end
        end
      end
    end
    send_command(CMD_COMPUTE, $urandom_range(0, 31), row, col, rand_value());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAP_ROWS:  sh_map_rows = data[6:0];
      CFG_MAP_COLS:  sh_map_cols = data[6:0];
      CFG_FILT_ROWS: sh_filt_rows = data[5:0];
      CFG_FILT_COLS: sh_filt_cols = data[5:0];
      CFG_CHANNELS:  sh_channels = data[5:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned mr, input int unsigned mc,
                               input int unsigned fr, input int unsigned fc,
                               input int unsigned nc);
    drain();
    write_reg(CFG_MAP_ROWS, mr);
    write_reg(CFG_MAP_COLS, mc);
    write_reg(CFG_FILT_ROWS, fr);
    write_reg(CFG_FILT_COLS, fc);
    write_reg(CFG_CHANNELS, nc);
  endtask

  // Small maps and filters mostly, with some illegal or boundary settings mixed in.
  task automatic random_setting();
    int unsigned mr, mc, fr, fc, nc, r;
    mr = $urandom_range(1, 8);
    mc = $urandom_range(1, 8);
    fr = $urandom_range(1, 3);
    fc = $urandom_range(1, 3);
    nc = $urandom_range(1, 3);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      mr = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
    end else if (r < 12) begin
      mc = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
    end else if (r < 16) begin
      fr = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
    end else if (r < 20) begin
      fc = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
    end else if (r < 25) begin
      nc = 0;
    end else if (r < 30) begin
      nc = $urandom_range(33, 63);
      fr = 1;
      fc = 1;
    end
    apply_setting(mr, mc, fr, fc, nc);
  endtask

  task automatic random_compute();
    int unsigned row, col;
    if ($urandom_range(0, 99) < 80 && window_reads(0, 0)) begin
      row = $urandom_range(0, sh_map_rows - sh_filt_rows);
      col = $urandom_range(0, sh_map_cols - sh_filt_cols);
    end else begin
      row = $urandom_range(0, 63);
      col = $urandom_range(0, 63);
    end
    issue_compute(row, col);
  endtask

  task automatic random_action();
    int unsigned r, nch;
    r = $urandom_range(0, 99);
    nch = clip_span(sh_channels, MFC_MAX_CHANNELS);
    if (r < 40) begin
      random_compute();
    end else if (r < 70) begin
      send_command(CMD_FEAT_WR, $urandom_range(0, nch - 1),
                   $urandom_range(0, clip_span(sh_map_rows, MFC_MAX_MAP_DIM) - 1),
                   $urandom_range(0, clip_span(sh_map_cols, MFC_MAX_MAP_DIM) - 1),
                   rand_value());
    end else if (r < 82) begin
      send_command(CMD_FILT_WR, $urandom_range(0, nch - 1),
                   $urandom_range(0, clip_span(sh_filt_rows, MFC_MAX_FILTER_DIM) - 1),
                   $urandom_range(0, clip_span(sh_filt_cols, MFC_MAX_FILTER_DIM) - 1),
                   rand_value());
    end else if (r < 88) begin
      // Filter word outside the filter store: must be refused.
      if ($urandom_range(0, 1)) begin
        send_command(CMD_FILT_WR, $urandom_range(0, 31), $urandom_range(32, 63),
                     $urandom_range(0, 63), rand_value());
      end else begin
        send_command(CMD_FILT_WR, $urandom_range(0, 31), $urandom_range(0, 63),
                     $urandom_range(32, 63), rand_value());
      end
    end else if (r < 93) begin
      send_command(CMD_UNUSED, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63), rand_value());
    end else begin
      send_command(CMD_FEAT_WR, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63), rand_value());
    end
  endtask

  // Flow control on the result side, with one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = draw_gap();
        out_stall <= (n != 0);
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    int phase, actions;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a 6 x 6 window on a 64 x 64 map does not fit past row or column 58.
    issue_compute(59, 0);
    issue_compute(0, 59);
    issue_compute(63, 63);
    send_command(CMD_UNUSED, 31, 63, 63, VAL_MIN);
    send_command(CMD_FILT_WR, 31, 32, 0, VAL_MAX);
    send_command(CMD_FILT_WR, 0, 5, 63, VAL_MAX);
    send_command(CMD_FEAT_WR, 31, 63, 63, VAL_MAX);
    send_command(CMD_FILT_WR, 31, 31, 31, VAL_MIN);
    send_command(CMD_FEAT_WR, 0, 63, 63, VAL_MIN);
    send_command(CMD_FILT_WR, 0, 0, 0, VAL_MIN);

    // Largest positive product, then the most negative one, at the far map corner.
    apply_setting(64, 64, 1, 1, 1);
    issue_compute(63, 63);
    send_command(CMD_FEAT_WR, 0, 63, 63, VAL_MAX);
    issue_compute(63, 63);
    issue_compute(0, 0);

    // No channels gives an empty sum; the spare register index changes nothing.
    apply_setting(64, 64, 1, 1, 0);
    issue_compute(10, 10);
    drain();
    write_reg(CFG_SPARE, 7'h7F);
    issue_compute(63, 63);

    apply_setting(0, 64, 1, 1, 1);
    issue_compute(0, 0);
    apply_setting(127, 127, 1, 1, 1);
    issue_compute(0, 0);
    apply_setting(64, 64, 0, 1, 1);
    issue_compute(0, 0);
    apply_setting(64, 64, 63, 63, 1);
    issue_compute(0, 0);

    sent_items = 0;
    phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      phase++;
      case (phase)
        1: apply_setting(64, 64, 32, 1, 1);
        2: apply_setting(64, 64, 1, 32, 1);
        3: apply_setting(64, 64, 1, 1, 63);
        4: apply_setting(1, 1, 1, 1, 1);
        default: random_setting();
      endcase
      quiet = (phase % 5 == 0);
      // The result side holds off while items keep coming, so the block backs up.
      if (phase == 2) begin
        quiet = 1'b1;
        hold_req = 1'b1;
      end
      actions = (phase <= 4) ? 6 : $urandom_range(20, 50);
      repeat (actions) begin
        if (sent_items < RANDOM_ITEMS) random_action();
      end
    end
    quiet = 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
